/* rtl/pipr_pkg.sv */
// shared types and constants for the ray-crossing point-in-polygon block
package pipr_pkg;

	// width of the result stream data, one flag padded to a byte
	localparam int OUT_TDATA_W = 8;

	// edge classification codes
	typedef enum logic [4:0] {
		CODE_MISS  = 5'd0,
		CODE_CROSS = 5'd1,
		CODE_OVER  = 5'd2,
		CODE_EXT   = 5'd3,
		CODE_T10   = 5'd10,
		CODE_T11   = 5'd11,
		CODE_T12   = 5'd12,
		CODE_T20   = 5'd20,
		CODE_T21   = 5'd21,
		CODE_T22   = 5'd22
	} code_t;

	// sign of an orientation test
	typedef struct packed {
		logic neg;
		logic zero;
	} sgn_t;

	// coordinate compares taken alongside the products
	typedef struct packed {
		logic degenerate;
		sgn_t y3_sign;
		sgn_t y4_sign;
		logic px_gt_x3;
		logic px_gt_x4;
		logic p_is_e3;
		logic p_is_e4;
		logic r_is_e3;
		logic r_is_e4;
		logic p_in_edge_box;
		logic r_in_edge_box;
		logic e3_in_ray_box;
		logic e4_in_ray_box;
		logic first;
		logic last;
	} geo_flags_t;

	// classified edge handed to the parity stage
	typedef struct packed {
		code_t code;
		logic  px_gt_min;
		logic  first;
		logic  last;
	} cls_t;

endpackage

/* rtl/pipr_geom.sv */
// edge sort, ray end, cross products and coordinate compares, registered
module pipr_geom #(
	parameter int COORD_WIDTH = 32
) (
	input  logic                                    clk,
	input  logic                                    en,
	input  logic signed [COORD_WIDTH-1:0]           px,
	input  logic signed [COORD_WIDTH-1:0]           py,
	input  logic signed [COORD_WIDTH-1:0]           ax,
	input  logic signed [COORD_WIDTH-1:0]           ay,
	input  logic signed [COORD_WIDTH-1:0]           bx,
	input  logic signed [COORD_WIDTH-1:0]           by,
	input  logic                                    first,
	input  logic                                    last,
	output logic signed [2*(COORD_WIDTH+2)-1:0]     prod_a_s2,
	output logic signed [2*(COORD_WIDTH+2)-1:0]     prod_b_s2,
	output logic signed [2*(COORD_WIDTH+2)-1:0]     prod_c_s2,
	output pipr_pkg::geo_flags_t                    flags_s2
);

	localparam int OpW   = COORD_WIDTH + 2;
	localparam int ProdW = 2 * OpW;

	logic signed [OpW-1:0] pxe, pye, axe, aye, bxe, bye;
	logic signed [OpW-1:0] x3, y3, x4, y4, mx, x2, ylo, yhi;
	logic signed [OpW-1:0] dx, dy, pdy, pdx, rdx;
	logic                  swap;
	pipr_pkg::geo_flags_t  flags_d;

	assign pxe = OpW'(px);
	assign pye = OpW'(py);
	assign axe = OpW'(ax);
	assign aye = OpW'(ay);
	assign bxe = OpW'(bx);
	assign bye = OpW'(by);

	// order the edge by x so that x3 <= x4
	assign swap = axe > bxe;
	assign x3   = swap ? bxe : axe;
	assign y3   = swap ? bye : aye;
	assign x4   = swap ? axe : bxe;
	assign y4   = swap ? aye : bye;

	// ray runs from the point to one past the rightmost x
	assign mx  = (pxe > x4) ? pxe : x4;
	assign x2  = mx + OpW'(1);
	assign ylo = (y3 < y4) ? y3 : y4;
	assign yhi = (y3 < y4) ? y4 : y3;

	assign dx  = x4 - x3;
	assign dy  = y4 - y3;
	assign pdy = pye - y3;
	assign pdx = pxe - x3;
	assign rdx = x2 - x3;

	always_comb begin
		flags_d.degenerate    = (axe == bxe) && (aye == bye);
		flags_d.y3_sign.neg   = y3 < pye;
		flags_d.y3_sign.zero  = y3 == pye;
		flags_d.y4_sign.neg   = y4 < pye;
		flags_d.y4_sign.zero  = y4 == pye;
		flags_d.px_gt_x3      = pxe > x3;
		flags_d.px_gt_x4      = pxe > x4;
		flags_d.p_is_e3       = (pxe == x3) && (pye == y3);
		flags_d.p_is_e4       = (pxe == x4) && (pye == y4);
		flags_d.r_is_e3       = (x2 == x3) && (pye == y3);
		flags_d.r_is_e4       = (x2 == x4) && (pye == y4);
		flags_d.p_in_edge_box = (x3 <= pxe) && (pxe <= x4) && (ylo <= pye) && (pye <= yhi);
		flags_d.r_in_edge_box = (x3 <= x2) && (x2 <= x4) && (ylo <= pye) && (pye <= yhi);
		flags_d.e3_in_ray_box = (pxe <= x3) && (x3 <= x2) && (y3 == pye);
		flags_d.e4_in_ray_box = (pxe <= x4) && (x4 <= x2) && (y4 == pye);
		flags_d.first         = first;
		flags_d.last          = last;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_a_s2 <= ProdW'(dx) * ProdW'(pdy);
			prod_b_s2 <= ProdW'(dy) * ProdW'(pdx);
			prod_c_s2 <= ProdW'(dy) * ProdW'(rdx);
			flags_s2  <= flags_d;
		end
	end

endmodule

/* rtl/pipr_classify.sv */
// orientation signs and edge classification, registered
module pipr_classify #(
	parameter int COORD_WIDTH = 32
) (
	input  logic                                clk,
	input  logic                                en,
	input  logic signed [2*(COORD_WIDTH+2)-1:0] prod_a,
	input  logic signed [2*(COORD_WIDTH+2)-1:0] prod_b,
	input  logic signed [2*(COORD_WIDTH+2)-1:0] prod_c,
	input  pipr_pkg::geo_flags_t                flags,
	output pipr_pkg::cls_t                      cls_s3
);

	localparam int DiffW = 2 * (COORD_WIDTH + 2) + 1;

	logic signed [DiffW-1:0] d341, d342;
	pipr_pkg::sgn_t          s341, s342, r123, r124;
	pipr_pkg::code_t         code_d;

	// touch of a vertex on the other segment's line
	function automatic pipr_pkg::code_t touch(input logic at_end, input logic in_box,
			input pipr_pkg::sgn_t turn, input pipr_pkg::code_t end_code,
			input pipr_pkg::code_t pos_code, input pipr_pkg::code_t neg_code);
		pipr_pkg::code_t c;
		if (at_end)
			c = end_code;
		else if (turn.zero)
			c = pipr_pkg::CODE_OVER;
		else if (!in_box)
			c = pipr_pkg::CODE_EXT;
		else if (!turn.neg)
			c = pos_code;
		else
			c = neg_code;
		return c;
	endfunction

	function automatic logic opposite(input pipr_pkg::sgn_t a, input pipr_pkg::sgn_t b);
		return !a.zero && !b.zero && (a.neg != b.neg);
	endfunction

	assign d341 = DiffW'(prod_a) - DiffW'(prod_b);
	assign d342 = DiffW'(prod_a) - DiffW'(prod_c);

	assign s341.zero = d341 == '0;
	assign s341.neg  = d341[DiffW-1];
	assign s342.zero = d342 == '0;
	assign s342.neg  = d342[DiffW-1];

	// the ray is horizontal and points right, so its tests reduce to y compares
	assign r123 = flags.y3_sign;
	assign r124 = flags.y4_sign;

	always_comb begin
		if (flags.degenerate)
			code_d = (r123.zero || r124.zero) ? pipr_pkg::CODE_CROSS : pipr_pkg::CODE_MISS;
		else if (opposite(r123, r124) && opposite(s341, s342))
			code_d = pipr_pkg::CODE_CROSS;
		else if (r123.zero && r124.zero && flags.px_gt_x4)
			code_d = pipr_pkg::CODE_MISS;
		else if (s341.zero)
			code_d = touch(flags.p_is_e3 || flags.p_is_e4, flags.p_in_edge_box, s342,
				pipr_pkg::CODE_T22, pipr_pkg::CODE_T20, pipr_pkg::CODE_T21);
		else if (s342.zero)
			code_d = touch(flags.r_is_e3 || flags.r_is_e4, flags.r_in_edge_box, s341,
				pipr_pkg::CODE_T22, pipr_pkg::CODE_T20, pipr_pkg::CODE_T21);
		else if (r123.zero)
			code_d = touch(flags.p_is_e3 || flags.r_is_e3, flags.e3_in_ray_box, r124,
				pipr_pkg::CODE_T12, pipr_pkg::CODE_T10, pipr_pkg::CODE_T11);
		else if (r124.zero)
			code_d = touch(flags.p_is_e4 || flags.r_is_e4, flags.e4_in_ray_box, r123,
				pipr_pkg::CODE_T12, pipr_pkg::CODE_T10, pipr_pkg::CODE_T11);
		else
			code_d = pipr_pkg::CODE_MISS;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cls_s3.code      <= code_d;
			cls_s3.px_gt_min <= flags.px_gt_x3;
			cls_s3.first     <= flags.first;
			cls_s3.last      <= flags.last;
		end
	end

endmodule

/* rtl/pipr_parity.sv */
// crossing parity, touch pairing, decided flag and result register
module pipr_parity (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           valid,
	input  pipr_pkg::cls_t cls,
	input  logic           out_ready,
	output logic           take,
	output logic           out_valid,
	output logic           out_inside
);

	typedef enum logic [1:0] {
		TOUCH_NONE = 2'd0,
		TOUCH_CW   = 2'd1,
		TOUCH_CCW  = 2'd2
	} touch_t;

	logic   par_q, dec_q, out_valid_q, out_inside_q;
	touch_t pend_q;
	logic   par_d, dec_d;
	touch_t pend_d;

	// a last edge needs the result register free or draining
	assign take       = valid && (!cls.last || !out_valid_q || out_ready);
	assign out_valid  = out_valid_q;
	assign out_inside = out_inside_q;

	always_comb begin
		par_d  = cls.first ? 1'b0 : par_q;
		dec_d  = cls.first ? 1'b0 : dec_q;
		pend_d = cls.first ? TOUCH_NONE : pend_q;
		if (!dec_d) begin
			case (cls.code)
				pipr_pkg::CODE_OVER: begin
					if (cls.px_gt_min)
						dec_d = 1'b1;
				end
				pipr_pkg::CODE_CROSS: par_d = !par_d;
				pipr_pkg::CODE_T20, pipr_pkg::CODE_T21,
				pipr_pkg::CODE_T22, pipr_pkg::CODE_T12: dec_d = 1'b1;
				pipr_pkg::CODE_T10: begin
					if (pend_d == TOUCH_CCW) begin
						par_d  = !par_d;
						pend_d = TOUCH_NONE;
					end else begin
						pend_d = TOUCH_CW;
					end
				end
				pipr_pkg::CODE_T11: begin
					if (pend_d == TOUCH_CW) begin
						par_d  = !par_d;
						pend_d = TOUCH_NONE;
					end else begin
						pend_d = TOUCH_CCW;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			par_q        <= 1'b0;
			dec_q        <= 1'b0;
			pend_q       <= TOUCH_NONE;
			out_valid_q  <= 1'b0;
			out_inside_q <= 1'b0;
		end else begin
			if (take) begin
				par_q  <= par_d;
				dec_q  <= dec_d;
				pend_q <= pend_d;
			end
			if (take && cls.last) begin
				out_valid_q  <= 1'b1;
				out_inside_q <= par_d && !dec_d;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

/* rtl/point_in_polygon_ray.sv */
// top level of the ray-crossing point-in-polygon tester
// usage:
//  - one transfer on the s_ side carries one polygon edge plus the query point;
//    s_tuser marks the first edge of a test (clears parity, pending touch and the
//    decided flag), s_tlast marks the last edge, which yields one result
//  - the m_ side carries one result per test: m_tdata bit 0 is 1 when the point
//    lies strictly inside, 0 when outside or on the boundary
//  - throughput: one edge per cycle while s_tready is high; the pipeline is input
//    register, product register (three cross products), classification register,
//    then the parity update feeding the result register
//  - the result sits on m_tvalid once the last edge has passed the input, product
//    and classification registers and its parity update has set the result register
//  - reset clears every stage's valid bit, the test state and the result register
//  - when the receiver stalls, a result waits in the result register while edges
//    keep flowing; only a further last edge reaching the parity stage holds, and
//    s_tready falls once the three stages ahead of it are full
module point_in_polygon_ray #(
	parameter int COORD_WIDTH = 32
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      s_tvalid,
	output logic                                      s_tready,
	// point_x, point_y, edge_ax, edge_ay, edge_bx, edge_by, zero padding to bytes
	input  logic [((6*COORD_WIDTH+7)/8)*8-1:0]        s_tdata,
	// first_edge
	input  logic                                      s_tuser,
	input  logic                                      s_tlast,
	output logic                                      m_tvalid,
	input  logic                                      m_tready,
	// is_inside, zero padding to a byte
	output logic [pipr_pkg::OUT_TDATA_W-1:0]          m_tdata
);

	localparam int ProdW = 2 * (COORD_WIDTH + 2);

	// stage 1: input register
	logic                          valid_s1;
	logic signed [COORD_WIDTH-1:0] px_s1, py_s1, ax_s1, ay_s1, bx_s1, by_s1;
	logic                          first_s1, last_s1;

	// stage 2: products and compares
	logic                          valid_s2;
	logic signed [ProdW-1:0]       prod_a_s2, prod_b_s2, prod_c_s2;
	pipr_pkg::geo_flags_t          flags_s2;

	// stage 3: classified edge
	logic                          valid_s3;
	pipr_pkg::cls_t                cls_s3;

	logic ready_1, ready_2, ready_3, take;
	logic is_inside;

	// each stage loads when empty or when the stage after it moves on
	assign ready_3  = !valid_s3 || take;
	assign ready_2  = !valid_s2 || ready_3;
	assign ready_1  = !valid_s1 || ready_2;
	assign s_tready = ready_1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (ready_1)
				valid_s1 <= s_tvalid;
			if (ready_2)
				valid_s2 <= valid_s1;
			if (ready_3)
				valid_s3 <= valid_s2;
		end
	end

	// input register, payload only
	always_ff @(posedge clk) begin
		if (ready_1) begin
			px_s1    <= $signed(s_tdata[0*COORD_WIDTH +: COORD_WIDTH]);
			py_s1    <= $signed(s_tdata[1*COORD_WIDTH +: COORD_WIDTH]);
			ax_s1    <= $signed(s_tdata[2*COORD_WIDTH +: COORD_WIDTH]);
			ay_s1    <= $signed(s_tdata[3*COORD_WIDTH +: COORD_WIDTH]);
			bx_s1    <= $signed(s_tdata[4*COORD_WIDTH +: COORD_WIDTH]);
			by_s1    <= $signed(s_tdata[5*COORD_WIDTH +: COORD_WIDTH]);
			first_s1 <= s_tuser;
			last_s1  <= s_tlast;
		end
	end

	pipr_geom #(
		.COORD_WIDTH(COORD_WIDTH)
	) u_geom (
		.clk      (clk),
		.en       (ready_2),
		.px       (px_s1),
		.py       (py_s1),
		.ax       (ax_s1),
		.ay       (ay_s1),
		.bx       (bx_s1),
		.by       (by_s1),
		.first    (first_s1),
		.last     (last_s1),
		.prod_a_s2(prod_a_s2),
		.prod_b_s2(prod_b_s2),
		.prod_c_s2(prod_c_s2),
		.flags_s2 (flags_s2)
	);

	pipr_classify #(
		.COORD_WIDTH(COORD_WIDTH)
	) u_classify (
		.clk   (clk),
		.en    (ready_3),
		.prod_a(prod_a_s2),
		.prod_b(prod_b_s2),
		.prod_c(prod_c_s2),
		.flags (flags_s2),
		.cls_s3(cls_s3)
	);

	// parity update and result register; non-last edges never wait on m_tready
	pipr_parity u_parity (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid     (valid_s3),
		.cls       (cls_s3),
		.out_ready (m_tready),
		.take      (take),
		.out_valid (m_tvalid),
		.out_inside(is_inside)
	);

	assign m_tdata = {{(pipr_pkg::OUT_TDATA_W-1){1'b0}}, is_inside};

	// a result only appears after a last edge has been taken by the parity stage
	a_result_from_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(take && cls_s3.last))
		else $error("result raised without a last edge");

	// input back-pressure only when every stage is full behind a stalled result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (valid_s1 && valid_s2 && valid_s3 && cls_s3.last &&
			m_tvalid && !m_tready))
		else $error("input stalled without a full pipeline");

	// an edge held in the parity stage is not lost
	a_hold_s3: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s3 && !take) |=> valid_s3)
		else $error("held edge dropped from stage 3");

endmodule
